// ===== src/assert_macros.svh =====
// Assertion helpers shared by the touch averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== src/tsam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_pkg
// Types, register codes and the shared axis finishing function of the touch
// sample averager.
// ----------------------------------------------------------------------------
package tsam_pkg;

  localparam int unsigned RawW    = 12;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CntW    = 5;
  localparam int unsigned DvdW    = RawW + SizeW;  // (v-lo)*(size-1)
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned CfgDataW = SizeW;

  localparam logic [RawW-1:0]  ResetLow    = 12'd200;
  localparam logic [RawW-1:0]  ResetHigh   = 12'd3900;
  localparam logic [SizeW-1:0] ResetWidth  = 13'd320;
  localparam logic [SizeW-1:0] ResetHeight = 13'd240;
  localparam logic [RawW-1:0]  CoordMax    = 12'd4095;

  typedef enum logic [2:0] {
    CfgRawXLow    = 3'd0,
    CfgRawXHigh   = 3'd1,
    CfgRawYLow    = 3'd2,
    CfgRawYHigh   = 3'd3,
    CfgScreenW    = 3'd4,
    CfgScreenH    = 3'd5,
    CfgOrient     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic            pen_down;
    logic [RawW-1:0] sample_x;
    logic [RawW-1:0] sample_y;
  } in_t;

  typedef struct packed {
    logic            [RawW-1:0] touch_x;
    logic            [RawW-1:0] touch_y;
    logic                       pressed;
    logic            [RawW-1:0] average_raw_x;
    logic            [RawW-1:0] average_raw_y;
    logic            [CntW-1:0] valid_samples;
  } out_t;

  typedef struct packed {
    logic [RawW-1:0]  x_low;
    logic [RawW-1:0]  x_high;
    logic [RawW-1:0]  y_low;
    logic [RawW-1:0]  y_high;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic [2:0]       orient;
  } cfg_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic            is_avg;   // burst ended with at least one valid sample
    logic [SumW-1:0] sum_x;
    logic [SumW-1:0] sum_y;
    logic [CntW-1:0] nvalid;
  } job_t;

  // Clamp the quotient to the screen, optionally mirror, saturate to 12 bits.
  function automatic logic [RawW-1:0] map_finish(input logic [DvdW-1:0]  m,
                                                 input logic [SizeW-1:0] size,
                                                 input logic             mirror);
    logic [SizeW-1:0] szm1;
    logic [SizeW-1:0] c;
    szm1 = size - 13'd1;
    if (m >= DvdW'(size)) begin
      c = szm1;
    end else begin
      c = m[SizeW-1:0];
    end
    if (mirror) begin
      c = szm1 - c;
    end
    if (size <= 13'd1) begin
      c = '0;
    end
    if (c > SizeW'(CoordMax)) begin
      return CoordMax;
    end
    return c[RawW-1:0];
  endfunction

endpackage

// ===== src/tsam_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_fifo
// Two-entry job queue between the sample front and the mapping back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsam_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsam_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tsam_pkg::job_t head_o
);
  import tsam_pkg::*;

  job_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `ASSERT_NEVER(a_fifo_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `ASSERT_NEVER(a_fifo_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

// ===== src/tsam_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_front
// Takes sample beats, sums in-window samples over a burst and queues a job
// on pen-up or at the end of each burst.
// ----------------------------------------------------------------------------
module tsam_front #(
  parameter int unsigned SAMPLE_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsam_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tsam_pkg::in_t  in_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output tsam_pkg::job_t push_data_o
);
  import tsam_pkg::*;

  localparam int unsigned BurstW = $clog2(SAMPLE_COUNT + 1);

  logic [BurstW-1:0] burst_q, burst_d;
  logic [CntW-1:0]   valid_q, valid_d;
  logic [SumW-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;

  logic              accept;
  logic              in_win;
  logic              burst_end;
  logic [BurstW-1:0] burst_nx;
  logic [CntW-1:0]   valid_nx;
  logic [SumW-1:0]   sum_x_nx, sum_y_nx;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign in_win = (in_data_i.sample_x >= cfg_i.x_low) && (in_data_i.sample_x <= cfg_i.x_high) &&
                  (in_data_i.sample_y >= cfg_i.y_low) && (in_data_i.sample_y <= cfg_i.y_high);

  assign burst_nx  = burst_q + BurstW'(1);
  assign burst_end = (burst_nx == BurstW'(SAMPLE_COUNT));
  assign valid_nx  = in_win ? valid_q + CntW'(1) : valid_q;
  assign sum_x_nx  = in_win ? sum_x_q + SumW'(in_data_i.sample_x) : sum_x_q;
  assign sum_y_nx  = in_win ? sum_y_q + SumW'(in_data_i.sample_y) : sum_y_q;

  always_comb begin
    burst_d     = burst_q;
    valid_d     = valid_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      if (!in_data_i.pen_down) begin
        push_o  = 1'b1;
        burst_d = '0;
        valid_d = '0;
        sum_x_d = '0;
        sum_y_d = '0;
      end else if (burst_end) begin
        push_o             = 1'b1;
        push_data_o.is_avg = (valid_nx != '0);
        push_data_o.sum_x  = sum_x_nx;
        push_data_o.sum_y  = sum_y_nx;
        push_data_o.nvalid = valid_nx;
        burst_d = '0;
        valid_d = '0;
        sum_x_d = '0;
        sum_y_d = '0;
      end else begin
        burst_d = burst_nx;
        valid_d = valid_nx;
        sum_x_d = sum_x_nx;
        sum_y_d = sum_y_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
      valid_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else begin
      burst_q <= burst_d;
      valid_q <= valid_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

endmodule

// ===== src/tsam_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsam_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tsam_pkg::DvdW-1:0]      dividend_i,
  input  logic [tsam_pkg::RawW-1:0]      divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [tsam_pkg::DvdW-1:0]      quot_o
);
  import tsam_pkg::*;

  localparam int unsigned StepW = $clog2(DivSteps + 1);

  logic [DvdW-1:0]  dvd_q;   // dividend bits shift out, quotient bits shift in
  logic [RawW-1:0]  rem_q;
  logic [RawW-1:0]  dvs_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [RawW:0]    rem_sh;
  logic             qbit;
  logic [RawW:0]    rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], qbit};
      rem_q <= qbit ? rem_sub[RawW-1:0] : rem_sh[RawW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == StepW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= StepW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

  `ASSERT_NEVER(a_div_start_while_busy, clk_i, rst_ni, start_i && busy_q)

endmodule

// ===== src/tsam_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_back
// Takes queued jobs; for a pressed one, averages the burst sums and maps both axes to the
// screen through the shared divider; holds the result beat for the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsam_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsam_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  tsam_pkg::job_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tsam_pkg::out_t out_data_o
);
  import tsam_pkg::*;

  typedef enum logic [5:0] {
    BIdle = 6'b000001,
    BAvgX = 6'b000010,
    BAvgY = 6'b000100,
    BMul  = 6'b001000,
    BMDiv = 6'b010000,
    BDone = 6'b100000
  } back_state_e;

  back_state_e     state_q, state_d;
  logic            axis_q, axis_d;       // 0: screen x, 1: screen y
  job_t            job_q, job_d;
  logic [RawW-1:0] avg_x_q, avg_x_d, avg_y_q, avg_y_d;
  logic [RawW-1:0] crd_x_q, crd_x_d, crd_y_q, crd_y_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            div_start;
  logic [DvdW-1:0] div_dvd;
  logic [RawW-1:0] div_dvs;
  logic            div_busy, div_done;
  logic [DvdW-1:0] div_quot;

  // Per-axis operand selection.
  logic             use_y;
  logic [RawW-1:0]  ax_src, ax_lo, ax_hi, ax_clamp, ax_span, ax_diff;
  logic [SizeW-1:0] ax_size;
  logic             ax_mirror, ax_degen;
  logic [DvdW-1:0]  ax_prod;
  logic [RawW-1:0]  ax_coord;

  assign use_y     = axis_q ^ cfg_i.orient[0];
  assign ax_src    = use_y ? avg_y_q : avg_x_q;
  assign ax_lo     = use_y ? cfg_i.y_low : cfg_i.x_low;
  assign ax_hi     = use_y ? cfg_i.y_high : cfg_i.x_high;
  assign ax_size   = axis_q ? cfg_i.height : cfg_i.width;
  assign ax_mirror = axis_q ? cfg_i.orient[2] : cfg_i.orient[1];
  assign ax_degen  = (ax_size <= 13'd1) || (ax_hi <= ax_lo);
  assign ax_clamp  = (ax_src < ax_lo) ? ax_lo : ((ax_src > ax_hi) ? ax_hi : ax_src);
  assign ax_span   = ax_hi - ax_lo;
  assign ax_diff   = ax_clamp - ax_lo;
  assign ax_prod   = DvdW'(ax_diff) * DvdW'(ax_size - 13'd1);
  assign ax_coord  = map_finish((state_q == BMDiv) ? div_quot : '0, ax_size, ax_mirror);

  tsam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    job_d       = job_q;
    avg_x_d     = avg_x_q;
    avg_y_d     = avg_y_q;
    crd_x_d     = crd_x_q;
    crd_y_d     = crd_y_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;

    unique case (state_q)
      BIdle: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = q_head_i;
          if (q_head_i.is_avg) begin
            div_start = 1'b1;
            div_dvd   = DvdW'(q_head_i.sum_x);
            div_dvs   = RawW'(q_head_i.nvalid);
            state_d   = BAvgX;
          end else begin
            crd_x_d = '0;
            crd_y_d = '0;
            state_d = BDone;
          end
        end
      end
      BAvgX: begin
        if (div_done) begin
          avg_x_d   = div_quot[RawW-1:0];
          div_start = 1'b1;
          div_dvd   = DvdW'(job_q.sum_y);
          div_dvs   = RawW'(job_q.nvalid);
          state_d   = BAvgY;
        end
      end
      BAvgY: begin
        if (div_done) begin
          avg_y_d = div_quot[RawW-1:0];
          axis_d  = 1'b0;
          state_d = BMul;
        end
      end
      BMul: begin
        if (ax_degen) begin
          // flat window or tiny screen: coordinate is 0 before mirroring
          if (axis_q) begin
            crd_y_d = ax_coord;
            state_d = BDone;
          end else begin
            crd_x_d = ax_coord;
            axis_d  = 1'b1;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = ax_prod;
          div_dvs   = ax_span;
          state_d   = BMDiv;
        end
      end
      BMDiv: begin
        if (div_done) begin
          if (axis_q) begin
            crd_y_d = ax_coord;
            state_d = BDone;
          end else begin
            crd_x_d = ax_coord;
            axis_d  = 1'b1;
            state_d = BMul;
          end
        end
      end
      BDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.touch_x       = crd_x_q;
          out_d.touch_y       = crd_y_q;
          out_d.pressed       = job_q.is_avg;
          out_d.average_raw_x = avg_x_q;
          out_d.average_raw_y = avg_y_q;
          out_d.valid_samples = job_q.nvalid;
          out_valid_d         = 1'b1;
          state_d             = BIdle;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    crd_x_q <= crd_x_d;
    crd_y_q <= crd_y_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      axis_q      <= 1'b0;
      avg_x_q     <= '0;
      avg_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      avg_x_q     <= avg_x_d;
      avg_y_q     <= avg_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_PROP(a_back_pressed_has_samples, clk_i, rst_ni,
               !out_valid_q || (out_q.pressed == (out_q.valid_samples != '0)))
  `ASSERT_PROP(a_back_pop_only_idle, clk_i, rst_ni, !pop_o || (state_q == BIdle))
  `ASSERT_NEVER(a_back_start_div_idle, clk_i, rst_ni, div_start && div_busy)

endmodule

// ===== src/touch_sample_average_map_core.sv =====
`timescale 1ns / 1ps
// Path: jobs pass the job queue, the back end's idle state and its done state into the output
// register; a pressed burst also runs four divides, one fewer per flat axis, between the two.
// Throughput: one sample beat per cycle while the two-entry job queue has room; the back
// end, bound by its single bit-serial divider, takes no new job until the last one is done.
// Reset: async active low; clears the burst, the kept averages and the handshakes and
// loads the window 200..3900, screen 320x240 and orientation 0.
// ----------------------------------------------------------------------------
// touch_sample_average_map_core
// Touch sample burst averager with window calibration and screen mapping.
// ----------------------------------------------------------------------------
module touch_sample_average_map_core #(
  parameter int unsigned SAMPLE_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [tsam_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tsam_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tsam_pkg::out_t                   out_data_o
);
  import tsam_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_full, q_empty, q_push, q_pop;
  job_t q_push_data, q_head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRawXLow:  cfg_d.x_low  = cfg_wdata_i[RawW-1:0];
        CfgRawXHigh: cfg_d.x_high = cfg_wdata_i[RawW-1:0];
        CfgRawYLow:  cfg_d.y_low  = cfg_wdata_i[RawW-1:0];
        CfgRawYHigh: cfg_d.y_high = cfg_wdata_i[RawW-1:0];
        CfgScreenW:  cfg_d.width  = cfg_wdata_i[SizeW-1:0];
        CfgScreenH:  cfg_d.height = cfg_wdata_i[SizeW-1:0];
        CfgOrient:   cfg_d.orient = cfg_wdata_i[2:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low  <= ResetLow;
      cfg_q.x_high <= ResetHigh;
      cfg_q.y_low  <= ResetLow;
      cfg_q.y_high <= ResetHigh;
      cfg_q.width  <= ResetWidth;
      cfg_q.height <= ResetHeight;
      cfg_q.orient <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsam_front #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  tsam_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  tsam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tsam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsam_checker
// Watches the config port and both beat channels of the touch averager,
// keeps its own copy of the registers and burst state, predicts each report
// and compares it field by field against what the block sends out.
// ----------------------------------------------------------------------------
module tsam_checker
  import tsam_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         reports_o,
  output int unsigned         touches_o
);

  localparam int unsigned MaxShown = 10;

  cfg_t             regs;
  logic [SumW-1:0]  acc_x, acc_y;
  logic [CntW-1:0]  beat_cnt, hit_cnt;
  logic [RawW-1:0]  avg_x, avg_y;
  out_t             reports_q[$];
  out_t             want, got;
  int unsigned      n_bad, n_reports, n_touches;

  function automatic int unsigned scale_axis(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi, input int unsigned size);
    int unsigned c, m;
    if (size <= 1 || hi <= lo) return 0;
    c = v;
    if (c < lo) c = lo;
    else if (c > hi) c = hi;
    m = (c - lo) * (size - 1) / (hi - lo);
    if (m >= size) m = size - 1;
    return m;
  endfunction

  function automatic int unsigned flip_axis(input int unsigned v, input int unsigned size);
    if (size <= 1) return 0;
    return size - 1 - v;
  endfunction

  function automatic void clear_burst();
    acc_x    = '0;
    acc_y    = '0;
    beat_cnt = '0;
    hit_cnt  = '0;
  endfunction

  // Folds one sample beat into the burst; returns 1 when a report is due.
  function automatic bit take_sample(input in_t beat, output out_t res);
    int unsigned tx, ty;
    res = '0;
    if (!beat.pen_down) begin
      clear_burst();
      res.average_raw_x = avg_x;
      res.average_raw_y = avg_y;
      return 1'b1;
    end
    beat_cnt = beat_cnt + 1'b1;
    if (beat.sample_x >= regs.x_low && beat.sample_x <= regs.x_high &&
        beat.sample_y >= regs.y_low && beat.sample_y <= regs.y_high) begin
      acc_x   = acc_x + beat.sample_x;
      acc_y   = acc_y + beat.sample_y;
      hit_cnt = hit_cnt + 1'b1;
    end
    if (beat_cnt < SAMPLE_COUNT) return 1'b0;
    res.valid_samples = hit_cnt;
    if (hit_cnt != 0) begin
      avg_x = RawW'(acc_x / hit_cnt);
      avg_y = RawW'(acc_y / hit_cnt);
      if (regs.orient[0]) begin
        tx = scale_axis(avg_y, regs.y_low, regs.y_high, regs.width);
        ty = scale_axis(avg_x, regs.x_low, regs.x_high, regs.height);
      end else begin
        tx = scale_axis(avg_x, regs.x_low, regs.x_high, regs.width);
        ty = scale_axis(avg_y, regs.y_low, regs.y_high, regs.height);
      end
      if (regs.orient[1]) tx = flip_axis(tx, regs.width);
      if (regs.orient[2]) ty = flip_axis(ty, regs.height);
      if (tx > CoordMax) tx = CoordMax;
      if (ty > CoordMax) ty = CoordMax;
      res.touch_x = RawW'(tx);
      res.touch_y = RawW'(ty);
      res.pressed = 1'b1;
    end
    res.average_raw_x = avg_x;
    res.average_raw_y = avg_y;
    clear_burst();
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs      = '{x_low: ResetLow, x_high: ResetHigh, y_low: ResetLow, y_high: ResetHigh,
                    width: ResetWidth, height: ResetHeight, orient: 3'd0};
      clear_burst();
      avg_x     = '0;
      avg_y     = '0;
      reports_q.delete();
      n_bad     = 0;
      n_reports = 0;
      n_touches = 0;
    end else begin
      // Compare before pushing: a report never belongs to a beat of the same edge.
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        n_reports++;
        if (reports_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MaxShown)
            $display("%0t: report with nothing pending: x %0d y %0d pressed %0d",
                     $realtime, got.touch_x, got.touch_y, got.pressed);
        end else begin
          want = reports_q.pop_front();
          if (want.pressed) n_touches++;
          if (got.touch_x !== want.touch_x || got.touch_y !== want.touch_y ||
              got.pressed !== want.pressed || got.average_raw_x !== want.average_raw_x ||
              got.average_raw_y !== want.average_raw_y ||
              got.valid_samples !== want.valid_samples) begin
            n_bad++;
            if (n_bad <= MaxShown)
              $display({"%0t: mismatch (exp/got) x %0d/%0d y %0d/%0d pressed %0d/%0d",
                        " avg_x %0d/%0d avg_y %0d/%0d valid %0d/%0d"}, $realtime,
                       want.touch_x, got.touch_x, want.touch_y, got.touch_y,
                       want.pressed, got.pressed, want.average_raw_x, got.average_raw_x,
                       want.average_raw_y, got.average_raw_y,
                       want.valid_samples, got.valid_samples);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgRawXLow:  regs.x_low  = cfg_wdata_i[RawW-1:0];
          CfgRawXHigh: regs.x_high = cfg_wdata_i[RawW-1:0];
          CfgRawYLow:  regs.y_low  = cfg_wdata_i[RawW-1:0];
          CfgRawYHigh: regs.y_high = cfg_wdata_i[RawW-1:0];
          CfgScreenW:  regs.width  = cfg_wdata_i;
          CfgScreenH:  regs.height = cfg_wdata_i;
          CfgOrient:   regs.orient = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (take_sample(in_data_i, want)) reports_q.push_back(want);
      end
    end
    mismatches_o <= n_bad;
    pending_o    <= reports_q.size();
    reports_o    <= n_reports;
    touches_o    <= n_touches;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample beats and register settings into the touch averager under a
// series of calibration windows, screen sizes, orientations and idle/stall
// mixes; the checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_top;
  import tsam_pkg::*;

  localparam int unsigned SampleCount     = 4;
  localparam int unsigned NumSettings     = 12;
  localparam int unsigned ItemsPerSetting = 70;
  localparam int unsigned SettleCycles    = 250;
  localparam int unsigned CycleLimit      = 1_000_000;

  typedef enum int unsigned {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    int unsigned xl, xh, yl, yh, w, h, o;
  } setting_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;

  int unsigned mismatches, pending, reports, touches;
  int unsigned send_idle_pct, stall_pct, beats_sent, cycles;
  setting_t    cur;

  touch_sample_average_map_core #(.SAMPLE_COUNT(SampleCount)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  tsam_checker #(.SAMPLE_COUNT(SampleCount)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .mismatches_o(mismatches), .pending_o(pending), .reports_o(reports),
    .touches_o(touches)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports still pending", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(input logic pen, input logic [RawW-1:0] x, input logic [RawW-1:0] y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pen_down: pen, sample_x: x, sample_y: y};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Drop valid, wait out every pending report and any burst still in the back end.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic setting_t pick_setting(input int unsigned idx);
    setting_t s;
    int unsigned t;
    case (idx)
      0: s = '{200, 3900, 200, 3900, 320, 240, 0};
      1: s = '{0, 4095, 0, 4095, 4096, 4096, 0};
      2: s = '{100, 3000, 500, 3500, 800, 480, 1};
      3: s = '{300, 3700, 250, 3800, 1024, 768, 2};
      4: s = '{0, 4095, 1000, 2000, 1, 0, 4};     // degenerate screen sizes
      5: s = '{3000, 1000, 200, 3900, 640, 480, 7}; // inverted x window
      6: s = '{2000, 2000, 1500, 1500, 320, 240, 3}; // single-point windows
      7: s = '{0, 4095, 0, 4095, 8191, 5000, 6};  // oversized, saturating mirrors
      default: begin
        s.xl = $urandom_range(4095);
        s.xh = $urandom_range(4095);
        s.yl = $urandom_range(4095);
        s.yh = $urandom_range(4095);
        if (s.xl > s.xh && $urandom_range(9) < 8) begin
          t = s.xl; s.xl = s.xh; s.xh = t;
        end
        if (s.yl > s.yh && $urandom_range(9) < 8) begin
          t = s.yl; s.yl = s.yh; s.yh = t;
        end
        s.w = $urandom_range(4096, 1);
        s.h = $urandom_range(4096, 1);
        s.o = $urandom_range(7);
      end
    endcase
    return s;
  endfunction

  // Mostly in-window readings, with full-range noise and window edges mixed in.
  function automatic logic [RawW-1:0] pick_raw(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && lo <= hi) return RawW'($urandom_range(hi, lo));
    if (r < 85) return RawW'($urandom);
    case ($urandom_range(5))
      0: return RawW'(lo - 1);
      1: return RawW'(lo);
      2: return RawW'(hi);
      3: return RawW'(hi + 1);
      4: return '0;
      default: return CoordMax;
    endcase
  endfunction

  task automatic run_directed();
    send_beat(1'b0, 12'd0, 12'd0);
    send_beat(1'b0, 12'd4095, 12'd4095);
    // two in-window corners, two out
    send_beat(1'b1, 12'd200, 12'd200);
    send_beat(1'b1, 12'd3900, 12'd3900);
    send_beat(1'b1, 12'd0, 12'd4095);
    send_beat(1'b1, 12'd4095, 12'd0);
    // nothing in window: not-pressed report
    send_beat(1'b1, 12'd199, 12'd200);
    send_beat(1'b1, 12'd200, 12'd3901);
    send_beat(1'b1, 12'd4095, 12'd4095);
    send_beat(1'b1, 12'd0, 12'd0);
    // pen lifted mid-burst
    send_beat(1'b1, 12'd1000, 12'd1000);
    send_beat(1'b1, 12'd2000, 12'd2000);
    send_beat(1'b0, 12'd0, 12'd4095);
    send_beat(1'b1, 12'd200, 12'd200);
    send_beat(1'b1, 12'd0, 12'd0);
    send_beat(1'b1, 12'd0, 12'd0);
    send_beat(1'b1, 12'd0, 12'd0);
    repeat (4) send_beat(1'b1, 12'd3900, 12'd3900);
  endtask

  initial begin
    int unsigned ph;
    idle_mode_e  mode;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgRawXLow;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    beats_sent    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < NumSettings; ph++) begin
      if (ph != 0) settle();
      cur = pick_setting(ph);
      write_reg(CfgRawXLow, cur.xl);
      write_reg(CfgRawXHigh, cur.xh);
      write_reg(CfgRawYLow, cur.yl);
      write_reg(CfgRawYHigh, cur.yh);
      write_reg(CfgScreenW, cur.w);
      write_reg(CfgScreenH, cur.h);
      write_reg(CfgOrient, cur.o);
      mode          = idle_mode_e'(ph % 4);
      send_idle_pct = (mode == IdleSender) ? 73 : (mode == IdleBoth) ? 8 : 0;
      stall_pct     = (mode == IdleReceiver) ? 73 : (mode == IdleBoth) ? 8 : 0;
      if (ph == 0) run_directed();
      repeat (ItemsPerSetting) begin
        send_beat($urandom_range(99) >= 8, pick_raw(cur.xl, cur.xh), pick_raw(cur.yl, cur.yh));
      end
    end
    settle();

    $display("Checked %0d reports (%0d with a touch) from %0d sample beats across %0d settings",
             reports, touches, beats_sent, NumSettings);
    $display("%0d mismatches, %0d reports left pending", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
